@@ src/ies_pkg.sv @@
// ----------------------------------------------------------------------------
// ies_pkg: shared types, constants and functions
// Types for the input item, the queued item, the set summary and the result,
// and the bit-count helpers used by the front end and the finalising stages.
// ----------------------------------------------------------------------------
package ies_pkg;

    // Largest number of integers kept in one set; later ones are dropped.
    localparam int unsigned MAX_ITEMS  = 1048576;
    localparam int unsigned CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int unsigned SIZE_W     = 24;
    localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};
    localparam int unsigned VAL_W      = 64;
    localparam int unsigned BITS_W     = 7;
    localparam int unsigned VB_W       = 4;
    // Product of an item count and a bit width.
    localparam int unsigned PROD_W     = CNT_W + BITS_W;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);

    // Encoding codes.
    localparam logic [1:0] ENC_PLAIN   = 2'd0;
    localparam logic [1:0] ENC_VARINT  = 2'd1;
    localparam logic [1:0] ENC_BITPACK = 2'd2;
    localparam logic [1:0] ENC_DELTA   = 2'd3;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
        logic             empty_req;
    } t_in;

    typedef struct packed {
        logic [3:0]        enc_code;
        logic [SIZE_W-1:0] enc_size;
        logic [SIZE_W-1:0] varint_bytes;
        logic [SIZE_W-1:0] bitpack_bytes;
        logic [SIZE_W-1:0] delta_bytes;
        logic [BITS_W-1:0] value_bits;
        logic [BITS_W-1:0] delta_bits;
        logic              values_signed;
        logic              deltas_signed;
    } t_out;

    // Item as classified by the front end.
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
        logic             empty_req;
        logic [VB_W-1:0]  vb_raw;
        logic [VB_W-1:0]  vb_zz;
    } t_item;

    // Summary of a finished set, handed to the finalising stages.
    typedef struct packed {
        logic              zero;
        logic [CNT_W-1:0]  count;
        logic [VAL_W-1:0]  first_value;
        logic [VAL_W-1:0]  raw_value_mask;
        logic [VAL_W-1:0]  zz_value_mask;
        logic [VAL_W-1:0]  raw_delta_mask;
        logic [VAL_W-1:0]  zz_delta_mask;
        logic [SIZE_W-1:0] raw_varint_total;
        logic [SIZE_W-1:0] zz_varint_total;
    } t_snap;

    // Zigzag mapping: sign moves to the least significant bit.
    function automatic logic [VAL_W-1:0] zz_map(input logic [VAL_W-1:0] v);
        return {v[VAL_W-2:0], 1'b0} ^ {VAL_W{v[VAL_W-1]}};
    endfunction

    // Number of significant bits; a zero word has none.
    function automatic logic [BITS_W-1:0] sig_bits(input logic [VAL_W-1:0] x);
        logic [BITS_W-1:0] b;
        b = '0;
        for (int i = 0; i < VAL_W; i++) begin
            if (x[i]) begin
                b = BITS_W'(i + 1);
            end
        end
        return b;
    endfunction

    // Varint bytes for a given number of significant bits; zero takes one byte.
    function automatic logic [VB_W-1:0] vbytes_of_bits(input logic [BITS_W-1:0] b);
        logic [VB_W-1:0] n;
        n = 4'd1;
        for (int k = 1; k < 10; k++) begin
            if (b > BITS_W'(7 * k)) begin
                n = VB_W'(k + 1);
            end
        end
        return n;
    endfunction

endpackage

@@ src/ies_front.sv @@
// ----------------------------------------------------------------------------
// ies_front: input stage
// Registers each incoming integer and works out its varint length, both raw
// and zigzag mapped, before it joins the queue.
// ----------------------------------------------------------------------------
module ies_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ies_pkg::t_in   i_in_data,
    output logic           o_item_valid,
    input  logic           i_item_ready,
    output ies_pkg::t_item o_item
);
    import ies_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    // The stage takes a new transfer whenever it is empty or being drained.
    assign o_in_ready   = !r_valid || i_item_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    // Classify the integer: varint lengths of the raw and the mapped value.
    always_comb begin
        n_item.value     = i_in_data.value;
        n_item.last      = i_in_data.last;
        n_item.empty_req = i_in_data.empty_req;
        n_item.vb_raw    = vbytes_of_bits(sig_bits(i_in_data.value));
        n_item.vb_zz     = vbytes_of_bits(sig_bits(zz_map(i_in_data.value)));
    end

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= n_item;
        end
    end

endmodule

@@ src/ies_fifo.sv @@
// ----------------------------------------------------------------------------
// ies_fifo: item queue
// A short register queue that decouples the input stage from the
// accumulator, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module ies_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  ies_pkg::t_item i_push_data,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output ies_pkg::t_item o_pop_data
);
    import ies_pkg::*;

    t_item            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != (PTR_W + 1)'(FIFO_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

@@ src/ies_accum.sv @@
// ----------------------------------------------------------------------------
// ies_accum: set accumulator
// Keeps the running count, first and previous value, the raw and zigzag
// masks of values and deltas and the varint totals, and hands a summary on
// at the end of each set.
// ----------------------------------------------------------------------------
module ies_accum (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_item_valid,
    output logic           o_item_ready,
    input  ies_pkg::t_item i_item,
    input  logic           i_fin_ready,
    output logic           o_snap_valid,
    output ies_pkg::t_snap o_snap
);
    import ies_pkg::*;

    logic [CNT_W-1:0]  r_count,   n_count;
    logic [VAL_W-1:0]  r_first,   n_first;
    logic [VAL_W-1:0]  r_prev,    n_prev;
    logic [VAL_W-1:0]  r_rvm,     n_rvm;
    logic [VAL_W-1:0]  r_zvm,     n_zvm;
    logic [VAL_W-1:0]  r_rdm,     n_rdm;
    logic [VAL_W-1:0]  r_zdm,     n_zdm;
    logic [SIZE_W-1:0] r_rvt,     n_rvt;
    logic [SIZE_W-1:0] r_zvt,     n_zvt;

    logic              ending;
    logic              pop;
    logic              take;
    logic [VAL_W-1:0]  delta;
    logic [SIZE_W:0]   rvt_sum;
    logic [SIZE_W:0]   zvt_sum;

    // An item that closes a set waits until the finalising stages can take it.
    assign ending       = i_item.empty_req || i_item.last;
    assign o_item_ready = !ending || i_fin_ready;
    assign pop          = i_item_valid && o_item_ready;
    assign take         = (r_count != CNT_W'(MAX_ITEMS));
    assign delta        = (r_count == '0) ? '0 : (i_item.value - r_prev);
    assign rvt_sum      = {1'b0, r_rvt} + (SIZE_W + 1)'(i_item.vb_raw);
    assign zvt_sum      = {1'b0, r_zvt} + (SIZE_W + 1)'(i_item.vb_zz);

    // Next state and the summary of a finished set.
    always_comb begin
        n_count = r_count;
        n_first = r_first;
        n_prev  = r_prev;
        n_rvm   = r_rvm;
        n_zvm   = r_zvm;
        n_rdm   = r_rdm;
        n_zdm   = r_zdm;
        n_rvt   = r_rvt;
        n_zvt   = r_zvt;
        if (pop && !i_item.empty_req && take) begin
            if (r_count == '0) begin
                n_first = i_item.value;
            end
            n_prev  = i_item.value;
            n_rvm   = r_rvm | i_item.value;
            n_zvm   = r_zvm | zz_map(i_item.value);
            n_rdm   = r_rdm | delta;
            n_zdm   = r_zdm | zz_map(delta);
            n_rvt   = rvt_sum[SIZE_W] ? SIZE_MAX : rvt_sum[SIZE_W-1:0];
            n_zvt   = zvt_sum[SIZE_W] ? SIZE_MAX : zvt_sum[SIZE_W-1:0];
            n_count = r_count + 1'b1;
        end

        o_snap_valid            = pop && ending;
        o_snap.zero             = i_item.empty_req || (n_count == '0);
        o_snap.count            = n_count;
        o_snap.first_value      = n_first;
        o_snap.raw_value_mask   = n_rvm;
        o_snap.zz_value_mask    = n_zvm;
        o_snap.raw_delta_mask   = n_rdm;
        o_snap.zz_delta_mask    = n_zdm;
        o_snap.raw_varint_total = n_rvt;
        o_snap.zz_varint_total  = n_zvt;

        // A closed set leaves everything cleared for the next one.
        if (pop && ending) begin
            n_count = '0;
            n_first = '0;
            n_prev  = '0;
            n_rvm   = '0;
            n_zvm   = '0;
            n_rdm   = '0;
            n_zdm   = '0;
            n_rvt   = '0;
            n_zvt   = '0;
        end
    end

    // Accumulator registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_first <= '0;
            r_prev  <= '0;
            r_rvm   <= '0;
            r_zvm   <= '0;
            r_rdm   <= '0;
            r_zdm   <= '0;
            r_rvt   <= '0;
            r_zvt   <= '0;
        end else begin
            r_count <= n_count;
            r_first <= n_first;
            r_prev  <= n_prev;
            r_rvm   <= n_rvm;
            r_zvm   <= n_zvm;
            r_rdm   <= n_rdm;
            r_zdm   <= n_zdm;
            r_rvt   <= n_rvt;
            r_zvt   <= n_zvt;
        end
    end

endmodule

@@ src/ies_final.sv @@
// ----------------------------------------------------------------------------
// ies_final: size evaluation pipeline
// Turns a set summary into bit widths, the three encoded sizes and the
// chosen encoding over four stages, ending in the output register.
// ----------------------------------------------------------------------------
module ies_final (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_snap_valid,
    output logic           o_snap_ready,
    input  ies_pkg::t_snap i_snap,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ies_pkg::t_out  o_out_data
);
    import ies_pkg::*;

    logic              en;

    // Stage S: registered summary.
    logic              r_s_valid;
    t_snap             r_s;

    // Stage A: widths and selections.
    logic              r_a_valid;
    logic              r_a_zero;
    logic              r_a_vs;
    logic              r_a_ds;
    logic              r_a_first_neg;
    logic [BITS_W-1:0] r_a_vbits;
    logic [BITS_W-1:0] r_a_dbits;
    logic [VB_W-1:0]   r_a_base;
    logic [SIZE_W-1:0] r_a_var;
    logic [CNT_W-1:0]  r_a_n;
    logic [CNT_W-1:0]  r_a_nm1;

    // Stage B: packed bit counts.
    logic              r_b_valid;
    logic              r_b_zero;
    logic              r_b_vs;
    logic              r_b_ds;
    logic              r_b_first_neg;
    logic [BITS_W-1:0] r_b_vbits;
    logic [BITS_W-1:0] r_b_dbits;
    logic [VB_W-1:0]   r_b_base;
    logic [SIZE_W-1:0] r_b_var;
    logic [PROD_W-1:0] r_b_pv;
    logic [PROD_W-1:0] r_b_pd;

    // Stage C: sizes.
    logic              r_c_valid;
    logic              r_c_zero;
    logic              r_c_vs;
    logic              r_c_ds;
    logic              r_c_first_neg;
    logic [BITS_W-1:0] r_c_vbits;
    logic [BITS_W-1:0] r_c_dbits;
    logic [SIZE_W-1:0] r_c_var;
    logic [SIZE_W-1:0] r_c_bp;
    logic [SIZE_W-1:0] r_c_dl;

    // Output register.
    logic              r_o_valid;
    t_out              r_o;

    logic              a_vs;
    logic              a_ds;
    logic              a_first_neg;
    logic [VAL_W-1:0]  a_base_val;
    logic [PROD_W+2:0] c_bp_sum;
    logic [PROD_W+2:0] c_dl_sum;
    t_out              n_o;
    logic [1:0]        sel_enc;
    logic [SIZE_W-1:0] sel_size;

    // The whole pipeline advances unless a finished result is held.
    assign en           = !r_o_valid || i_out_ready;
    assign o_snap_ready = en;
    assign o_out_valid  = r_o_valid;
    assign o_out_data   = r_o;

    assign a_vs        = r_s.raw_value_mask[VAL_W-1];
    assign a_ds        = r_s.raw_delta_mask[VAL_W-1];
    assign a_first_neg = r_s.first_value[VAL_W-1];
    assign a_base_val  = a_first_neg ? zz_map(r_s.first_value) : r_s.first_value;

    // Rounded-up bytes plus the width byte, and the base for delta.
    assign c_bp_sum = (PROD_W + 3)'((r_b_pv + PROD_W'(7)) >> 3) + (PROD_W + 3)'(1);
    assign c_dl_sum = (PROD_W + 3)'((r_b_pd + PROD_W'(7)) >> 3) + (PROD_W + 3)'(1)
                    + (PROD_W + 3)'(r_b_base);

    // Choice of encoding: bit-pack, then varint, then delta on ties.
    always_comb begin
        sel_enc  = ENC_BITPACK;
        sel_size = r_c_bp;
        if (r_c_var < sel_size) begin
            sel_enc  = ENC_VARINT;
            sel_size = r_c_var;
        end
        if (r_c_dl < sel_size) begin
            sel_enc  = ENC_DELTA;
            sel_size = r_c_dl;
        end
        n_o.enc_code[1:0]      = sel_enc;
        n_o.enc_code[2]        = 1'b0;
        n_o.enc_code[3]        = (sel_enc == ENC_DELTA) ? r_c_first_neg : r_c_vs;
        n_o.enc_size           = sel_size;
        n_o.varint_bytes       = r_c_var;
        n_o.bitpack_bytes      = r_c_bp;
        n_o.delta_bytes        = r_c_dl;
        n_o.value_bits         = r_c_vbits;
        n_o.delta_bits         = r_c_dbits;
        n_o.values_signed      = r_c_vs;
        n_o.deltas_signed      = r_c_ds;
        // An empty set reports plain encoding and nothing else.
        if (r_c_zero) begin
            n_o          = '0;
            n_o.enc_code = {2'b00, ENC_PLAIN};
        end
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_s_valid <= i_snap_valid;
            r_a_valid <= r_s_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_o_valid <= r_c_valid;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s <= i_snap;

            r_a_zero      <= r_s.zero;
            r_a_vs        <= a_vs;
            r_a_ds        <= a_ds;
            r_a_first_neg <= a_first_neg;
            r_a_vbits     <= sig_bits(a_vs ? r_s.zz_value_mask : r_s.raw_value_mask);
            r_a_dbits     <= sig_bits(a_ds ? r_s.zz_delta_mask : r_s.raw_delta_mask);
            r_a_base      <= vbytes_of_bits(sig_bits(a_base_val));
            r_a_var       <= a_vs ? r_s.zz_varint_total : r_s.raw_varint_total;
            r_a_n         <= r_s.count;
            r_a_nm1       <= r_s.count - 1'b1;

            r_b_zero      <= r_a_zero;
            r_b_vs        <= r_a_vs;
            r_b_ds        <= r_a_ds;
            r_b_first_neg <= r_a_first_neg;
            r_b_vbits     <= r_a_vbits;
            r_b_dbits     <= r_a_dbits;
            r_b_base      <= r_a_base;
            r_b_var       <= r_a_var;
            r_b_pv        <= PROD_W'(r_a_n) * PROD_W'(r_a_vbits);
            r_b_pd        <= PROD_W'(r_a_nm1) * PROD_W'(r_a_dbits);

            r_c_zero      <= r_b_zero;
            r_c_vs        <= r_b_vs;
            r_c_ds        <= r_b_ds;
            r_c_first_neg <= r_b_first_neg;
            r_c_vbits     <= r_b_vbits;
            r_c_dbits     <= r_b_dbits;
            r_c_var       <= r_b_var;
            r_c_bp        <= (c_bp_sum > (PROD_W + 3)'(SIZE_MAX)) ? SIZE_MAX
                                                                 : c_bp_sum[SIZE_W-1:0];
            r_c_dl        <= (c_dl_sum > (PROD_W + 3)'(SIZE_MAX)) ? SIZE_MAX
                                                                 : c_dl_sum[SIZE_W-1:0];

            r_o <= n_o;
        end
    end

endmodule

@@ src/integer_encoding_selector.sv @@
// ----------------------------------------------------------------------------
// integer_encoding_selector: compact integer encoding choice
// Throughput: one integer per cycle, set by the accumulator loop, if not stalled.
// The result passes through the input stage, the queue, the summary register
// and four evaluation stages, and is held while the output is stalled.
// Synchronous active-low reset empties the queue and the pipeline and clears
// every running total; no result is pending after it.
// ----------------------------------------------------------------------------
module integer_encoding_selector (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ies_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ies_pkg::t_out o_out_data
);
    import ies_pkg::*;

    logic  front_valid;
    logic  front_ready;
    t_item front_item;
    logic  q_valid;
    logic  q_ready;
    t_item q_item;
    logic  snap_valid;
    logic  snap_ready;
    t_snap snap;

    // Front end: registers and classifies each integer.
    ies_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_item_valid (front_valid),
        .i_item_ready (front_ready),
        .o_item       (front_item)
    );

    // Queue between the front end and the accumulator.
    ies_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_item),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_item)
    );

    // Running summary of the current set.
    ies_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .o_item_ready (q_ready),
        .i_item       (q_item),
        .i_fin_ready  (snap_ready),
        .o_snap_valid (snap_valid),
        .o_snap       (snap)
    );

    // Size evaluation and output register.
    ies_final u_final (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .o_snap_ready (snap_ready),
        .i_snap       (snap),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

    // The chosen size is never larger than the bit-pack size.
    a_best_le_bitpack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.enc_size <= o_out_data.bitpack_bytes))
        else $error("best size exceeds bit-pack size");

    // A plain result carries no sizes at all.
    a_plain_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.enc_code[1:0] == ENC_PLAIN))
        |-> ((o_out_data.enc_size == '0) && (o_out_data.bitpack_bytes == '0)
             && (o_out_data.varint_bytes == '0) && (o_out_data.delta_bytes == '0)))
        else $error("plain result with non-zero sizes");

    // When delta is chosen, the chosen size is the delta size.
    a_best_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.enc_code[1:0] == ENC_DELTA))
        |-> (o_out_data.enc_size == o_out_data.delta_bytes))
        else $error("delta chosen but size differs");

    // Bit widths never exceed the word width.
    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.value_bits <= BITS_W'(VAL_W))
                         && (o_out_data.delta_bits <= BITS_W'(VAL_W))))
        else $error("bit width out of range");

endmodule
